@@ rtl/fgt_pkg.sv @@
// Shared types and constants for the frame geometric transform block.
package fgt_pkg;

	// Transform selection codes (codes 9 to 15 behave as identity)
	typedef enum logic [3:0] {
		MODE_IDENT  = 4'd0,
		MODE_MIRLR  = 4'd1,
		MODE_MIRUD  = 4'd2,
		MODE_ROT90  = 4'd3,
		MODE_ROT180 = 4'd4,
		MODE_ROT270 = 4'd5,
		MODE_DOWN2  = 4'd6,
		MODE_UP2    = 4'd7,
		MODE_CROP   = 4'd8
	} mode_t;

	// Register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_MODE      = 3'd0,
		REG_FRAME_ROWS = 3'd1,
		REG_FRAME_COLS = 3'd2,
		REG_CROP_ROW  = 3'd3,
		REG_CROP_COL  = 3'd4,
		REG_CROP_ROWS = 3'd5,
		REG_CROP_COLS = 3'd6
	} reg_idx_t;

	// Item opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_READ,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Configuration register contents
	typedef struct packed {
		mode_t      mode;
		logic [9:0] frame_rows;
		logic [9:0] frame_cols;
		logic [8:0] crop_row;
		logic [8:0] crop_col;
		logic [9:0] crop_rows;
		logic [9:0] crop_cols;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic idle;      // ready for a new input beat
		logic map_en;    // register mapped coordinates, clear taps and sum
		logic wr_en;     // store the captured pixel if it lies in the frame
		logic rd_en;     // issue one tap read
		logic load_out;  // move the result into the output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_write;
		logic rd_err;
		logic last_tap;
		logic out_free;
	} stat_t;

endpackage

@@ rtl/fgt_regs.sv @@
// Configuration register file behind the APB-style port.
module fgt_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fgt_pkg::APB_AW-1:0] paddr,
	input  logic [fgt_pkg::APB_DW-1:0] pwdata,
	output logic [fgt_pkg::APB_DW-1:0] prdata,
	output fgt_pkg::cfg_t              cfg
);
	import fgt_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_stb;

	assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
	assign wr_stb = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= MODE_IDENT;
			cfg_q.frame_rows <= 10'd512;
			cfg_q.frame_cols <= 10'd512;
			cfg_q.crop_row   <= 9'd0;
			cfg_q.crop_col   <= 9'd0;
			cfg_q.crop_rows  <= 10'd1;
			cfg_q.crop_cols  <= 10'd1;
		end else if (wr_stb) begin
			unique case (idx)
				REG_MODE:       cfg_q.mode       <= mode_t'(pwdata[3:0]);
				REG_FRAME_ROWS: cfg_q.frame_rows <= pwdata[9:0];
				REG_FRAME_COLS: cfg_q.frame_cols <= pwdata[9:0];
				REG_CROP_ROW:   cfg_q.crop_row   <= pwdata[8:0];
				REG_CROP_COL:   cfg_q.crop_col   <= pwdata[8:0];
				REG_CROP_ROWS:  cfg_q.crop_rows  <= pwdata[9:0];
				REG_CROP_COLS:  cfg_q.crop_cols  <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	// Read-back mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_MODE:       prdata = APB_DW'(cfg_q.mode);
			REG_FRAME_ROWS: prdata = APB_DW'(cfg_q.frame_rows);
			REG_FRAME_COLS: prdata = APB_DW'(cfg_q.frame_cols);
			REG_CROP_ROW:   prdata = APB_DW'(cfg_q.crop_row);
			REG_CROP_COL:   prdata = APB_DW'(cfg_q.crop_col);
			REG_CROP_ROWS:  prdata = APB_DW'(cfg_q.crop_rows);
			REG_CROP_COLS:  prdata = APB_DW'(cfg_q.crop_cols);
			default:        prdata = '0;
		endcase
	end

endmodule

@@ rtl/fgt_ctrl.sv @@
// Sequencing state machine: capture, map, tap reads, drain, result hand-off.
module fgt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  fgt_pkg::stat_t stat,
	output fgt_pkg::cmd_t  cmd
);
	import fgt_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nx = ST_MAP;
			end
			ST_MAP: begin
				if (stat.is_write)     state_nx = ST_IDLE;
				else if (stat.rd_err)  state_nx = ST_DONE;
				else                   state_nx = ST_READ;
			end
			ST_READ: begin
				if (stat.last_tap) state_nx = ST_DRAIN;
			end
			ST_DRAIN: state_nx = ST_DONE;
			ST_DONE: begin
				if (stat.out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:  cmd.idle = 1'b1;
			ST_MAP: begin
				cmd.map_en = 1'b1;
				cmd.wr_en  = stat.is_write;
			end
			ST_READ:  cmd.rd_en = 1'b1;
			ST_DRAIN: ;
			ST_DONE:  cmd.load_out = stat.out_free;
			default:  ;
		endcase
	end

endmodule

@@ rtl/fgt_dpath.sv @@
// Datapath: input capture, coordinate mapping, frame memory, tap sum, output register.
module fgt_dpath #(
	parameter int MAX_ROWS = 512,
	parameter int MAX_COLS = 512
) (
	input  logic          clk,
	input  logic          arst_n,
	input  fgt_pkg::cfg_t cfg,
	input  fgt_pkg::cmd_t cmd,
	output fgt_pkg::stat_t stat,
	input  logic          in_valid,
	input  logic          opcode,
	input  logic [9:0]    row,
	input  logic [9:0]    col,
	input  logic [7:0]    pixel_in,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    pixel_out,
	output logic          range_error
);
	import fgt_pkg::*;

	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLS);
	localparam int AW    = RW + CW;
	localparam int DEPTH = 1 << AW;

	// Captured input beat
	logic       op_q;
	logic [9:0] row_q, col_q;
	logic [7:0] pix_q;

	// Clamped frame size
	logic [9:0] dim_r, dim_c;

	// Mapping results
	logic [10:0] orows, ocols;
	logic [9:0]  crop_h, crop_w, row_rem, col_rem, crop_oh, crop_ow;
	logic [9:0]  up_r0, up_r1, up_c0, up_c1;
	logic [9:0]  ra, rb, ca, cb;
	logic [1:0]  nlast, shift;
	logic        map_err, wr_ok;

	// Registered mapping and tap state
	logic [9:0]  ra_q, rb_q, ca_q, cb_q;
	logic [1:0]  nlast_q, shift_q, tap_q;
	logic        err_q;

	// Frame memory
	logic [7:0]    mem_q [0:DEPTH-1];
	logic [AW-1:0] wr_addr, rd_addr;
	logic [9:0]    tap_r, tap_c;
	logic [7:0]    rdata_s1;
	logic          rd_vld_s1;
	logic [9:0]    sum_q;

	// Output register
	logic       out_valid_q;
	logic [7:0] pixel_out_q;
	logic       range_error_q;

	// Input capture
	always_ff @(posedge clk) begin
		if (in_valid && cmd.idle) begin
			op_q  <= opcode;
			row_q <= row;
			col_q <= col;
			pix_q <= pixel_in;
		end
	end

	// Frame size saturates to 1 .. MAX
	always_comb begin
		if (cfg.frame_rows == 10'd0)                   dim_r = 10'd1;
		else if (32'(cfg.frame_rows) > MAX_ROWS)       dim_r = 10'(MAX_ROWS);
		else                                           dim_r = cfg.frame_rows;
		if (cfg.frame_cols == 10'd0)                   dim_c = 10'd1;
		else if (32'(cfg.frame_cols) > MAX_COLS)       dim_c = 10'(MAX_COLS);
		else                                           dim_c = cfg.frame_cols;
	end

	// Crop window, cut at the frame edge
	always_comb begin
		crop_h  = (cfg.crop_rows == 10'd0) ? 10'd1 : cfg.crop_rows;
		crop_w  = (cfg.crop_cols == 10'd0) ? 10'd1 : cfg.crop_cols;
		row_rem = dim_r - {1'b0, cfg.crop_row};
		col_rem = dim_c - {1'b0, cfg.crop_col};
		if ({1'b0, cfg.crop_row} < dim_r) crop_oh = (crop_h < row_rem) ? crop_h : row_rem;
		else                              crop_oh = 10'd0;
		if ({1'b0, cfg.crop_col} < dim_c) crop_ow = (crop_w < col_rem) ? crop_w : col_rem;
		else                              crop_ow = 10'd0;
	end

	// Upscale neighbours with edge replication
	always_comb begin
		up_r0 = {1'b0, row_q[9:1]};
		up_c0 = {1'b0, col_q[9:1]};
		up_r1 = ((up_r0 + 10'd1) < dim_r) ? up_r0 + 10'd1 : dim_r - 10'd1;
		up_c1 = ((up_c0 + 10'd1) < dim_c) ? up_c0 + 10'd1 : dim_c - 10'd1;
	end

	// Output size and source coordinates
	always_comb begin
		orows = {1'b0, dim_r};
		ocols = {1'b0, dim_c};
		ra    = row_q;
		ca    = col_q;
		nlast = 2'd0;
		shift = 2'd0;
		case (cfg.mode) inside
			MODE_ROT90, MODE_ROT270: begin
				orows = {1'b0, dim_c};
				ocols = {1'b0, dim_r};
			end
			MODE_DOWN2: begin
				orows = {2'b0, dim_r[9:1]};
				ocols = {2'b0, dim_c[9:1]};
			end
			MODE_UP2: begin
				orows = {dim_r, 1'b0};
				ocols = {dim_c, 1'b0};
			end
			MODE_CROP: begin
				orows = {1'b0, crop_oh};
				ocols = {1'b0, crop_ow};
			end
			default: ;
		endcase

		case (cfg.mode)
			MODE_MIRLR:  ca = dim_c - 10'd1 - col_q;
			MODE_MIRUD:  ra = dim_r - 10'd1 - row_q;
			MODE_ROT90: begin
				ra = col_q;
				ca = dim_c - 10'd1 - row_q;
			end
			MODE_ROT180: begin
				ra = dim_r - 10'd1 - row_q;
				ca = dim_c - 10'd1 - col_q;
			end
			MODE_ROT270: begin
				ra = dim_r - 10'd1 - col_q;
				ca = row_q;
			end
			MODE_DOWN2: begin
				ra = {row_q[8:0], 1'b0};
				ca = {col_q[8:0], 1'b0};
			end
			MODE_UP2: begin
				ra    = up_r0;
				ca    = up_c0;
				nlast = {row_q[0] & col_q[0], row_q[0] | col_q[0]};
				shift = 2'(row_q[0]) + 2'(col_q[0]);
			end
			MODE_CROP: begin
				ra = 10'(cfg.crop_row) + row_q;
				ca = 10'(cfg.crop_col) + col_q;
			end
			default: ;
		endcase

		// second neighbour only differs on the odd axis of an upscale
		rb = (cfg.mode == MODE_UP2 && row_q[0]) ? up_r1 : ra;
		cb = (cfg.mode == MODE_UP2 && col_q[0]) ? up_c1 : ca;

		map_err = ({1'b0, row_q} >= orows) || ({1'b0, col_q} >= ocols);
		wr_ok   = (row_q < dim_r) && (col_q < dim_c);
	end

	// Mapping register
	always_ff @(posedge clk) begin
		if (cmd.map_en) begin
			ra_q    <= ra;
			rb_q    <= rb;
			ca_q    <= ca;
			cb_q    <= cb;
			nlast_q <= nlast;
			shift_q <= shift;
			err_q   <= map_err;
		end
	end

	// Tap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= 2'd0;
		end else if (cmd.map_en) begin
			tap_q <= 2'd0;
		end else if (cmd.rd_en) begin
			tap_q <= tap_q + 2'd1;
		end
	end

	// Tap address: column toggles fastest, row on the upper tap bit for four taps
	always_comb begin
		tap_r   = (nlast_q[1] ? tap_q[1] : tap_q[0]) ? rb_q : ra_q;
		tap_c   = tap_q[0] ? cb_q : ca_q;
		rd_addr = {RW'(tap_r), CW'(tap_c)};
		wr_addr = {RW'(row_q), CW'(col_q)};
	end

	// Frame memory, one write or one read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_ok) begin
			mem_q[wr_addr] <= pix_q;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
		end
	end

	// Tap sum
	always_ff @(posedge clk) begin
		if (cmd.map_en) begin
			sum_q <= 10'd0;
		end else if (rd_vld_s1) begin
			sum_q <= sum_q + 10'(rdata_s1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			pixel_out_q   <= err_q ? 8'd0 : 8'(sum_q >> shift_q);
			range_error_q <= err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_out   = pixel_out_q;
	assign range_error = range_error_q;

	// Status
	assign stat.is_write = (op_q == OP_WRITE);
	assign stat.rd_err   = map_err;
	assign stat.last_tap = (tap_q == nlast_q);
	assign stat.out_free = !out_valid_q || !out_stall;

endmodule

@@ rtl/frame_geometric_transform_core.sv @@
// Top level of the frame geometric transform: register file, controller, datapath.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  in       | in_valid / in_stall     | opcode, row, col, pixel_in
//  out      | out_valid / out_stall   | pixel_out, range_error
//  config   | psel, penable, pready   | paddr, pwrite, pwdata, prdata
//
// A write beat is captured, then mapped and stored; an out-of-range read is captured,
// mapped and handed off. Other reads add a drain step and need frame memory reads: 1,
// or 2 or 4 for the odd positions of the 2x upscale, one per cycle on the single port.
// Reset clears the registers to their defaults; the frame memory is not cleared.
// A stalled result waits in the output register; the next input beat is taken
// meanwhile and holds in its final step until the register frees.
module frame_geometric_transform_core #(
	parameter int MAX_ROWS = 512,
	parameter int MAX_COLS = 512
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input items
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [9:0]                 row,
	input  logic [9:0]                 col,
	input  logic [7:0]                 pixel_in,
	// result items
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 pixel_out,
	output logic                       range_error,
	// configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fgt_pkg::APB_AW-1:0] paddr,
	input  logic [fgt_pkg::APB_DW-1:0] pwdata,
	output logic [fgt_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import fgt_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	assign pready   = 1'b1;
	assign in_stall = !cmd.idle;

	fgt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	fgt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.cmd      (cmd)
	);

	fgt_dpath #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.stat        (stat),
		.in_valid    (in_valid),
		.opcode      (opcode),
		.row         (row),
		.col         (col),
		.pixel_in    (pixel_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_out   (pixel_out),
		.range_error (range_error)
	);

endmodule

@@ sim/fgt_readout_checker.sv @@
// Watches the frame transform channels, models the frame and its read-out, and counts mismatches.
module fgt_readout_checker
	import fgt_pkg::*;
#(
	parameter int MAX_ROWS = 512,
	parameter int MAX_COLS = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              opcode,
	input  logic [9:0]        row,
	input  logic [9:0]        col,
	input  logic [7:0]        pixel_in,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [7:0]        pixel_out,
	input  logic              range_error,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output int                fail_total,
	output int                reads_open,
	output int                results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// one read-out beat: pixel value and out-of-range flag
	typedef struct packed {
		logic [7:0] px;
		logic       err;
	} readout_t;

	readout_t   pending_px [$];
	bit [7:0]   frame_px [MAX_ROWS*MAX_COLS];

	// shadow of the configuration registers
	logic [3:0] xf_mode;
	logic [9:0] frame_rows_q;
	logic [9:0] frame_cols_q;
	logic [8:0] crop_row_q;
	logic [8:0] crop_col_q;
	logic [9:0] crop_rows_q;
	logic [9:0] crop_cols_q;

	initial fail_total = 0;
	initial results_checked = 0;

	// frame size register saturated to 1 .. max
	function automatic int unsigned frame_extent(logic [9:0] v, int unsigned maxv);
		int unsigned e;
		e = v;
		if (e < 1)
			e = 1;
		else if (e > maxv)
			e = maxv;
		return e;
	endfunction

	function automatic int unsigned px_at(int unsigned r, int unsigned c);
		int unsigned v;
		if (r >= MAX_ROWS || c >= MAX_COLS)
			v = 0;
		else
			v = frame_px[r*MAX_COLS + c];
		return v;
	endfunction

	// pixel seen at output coordinate (r, c) under the current transform
	function automatic readout_t xform_pixel(int unsigned r, int unsigned c);
		int unsigned fr, fc, orows, ocols, h, w, r0, c0, r1, c1, v;
		readout_t res;
		fr = frame_extent(frame_rows_q, MAX_ROWS);
		fc = frame_extent(frame_cols_q, MAX_COLS);
		v = 0;
		case (xf_mode)
			MODE_ROT90, MODE_ROT270: begin
				orows = fc;
				ocols = fr;
			end
			MODE_DOWN2: begin
				orows = fr / 2;
				ocols = fc / 2;
			end
			MODE_UP2: begin
				orows = 2 * fr;
				ocols = 2 * fc;
			end
			MODE_CROP: begin
				h = (crop_rows_q == 0) ? 1 : crop_rows_q;
				w = (crop_cols_q == 0) ? 1 : crop_cols_q;
				orows = (crop_row_q < fr) ? ((h < fr - crop_row_q) ? h : fr - crop_row_q) : 0;
				ocols = (crop_col_q < fc) ? ((w < fc - crop_col_q) ? w : fc - crop_col_q) : 0;
			end
			default: begin
				orows = fr;
				ocols = fc;
			end
		endcase
		if (r >= orows || c >= ocols) begin
			res.px = '0;
			res.err = 1'b1;
		end else begin
			case (xf_mode)
				MODE_MIRLR:  v = px_at(r, fc - 1 - c);
				MODE_MIRUD:  v = px_at(fr - 1 - r, c);
				MODE_ROT90:  v = px_at(c, fc - 1 - r);
				MODE_ROT180: v = px_at(fr - 1 - r, fc - 1 - c);
				MODE_ROT270: v = px_at(fr - 1 - c, r);
				MODE_DOWN2:  v = px_at(2 * r, 2 * c);
				MODE_UP2: begin
					// neighbours past the last row or column replicate the edge
					r0 = r >> 1;
					c0 = c >> 1;
					r1 = (r0 + 1 < fr) ? r0 + 1 : fr - 1;
					c1 = (c0 + 1 < fc) ? c0 + 1 : fc - 1;
					case ({r[0], c[0]})
						2'b00: v = px_at(r0, c0);
						2'b10: v = (px_at(r0, c0) + px_at(r1, c0)) / 2;
						2'b01: v = (px_at(r0, c0) + px_at(r0, c1)) / 2;
						default: v = (px_at(r0, c0) + px_at(r0, c1)
							+ px_at(r1, c0) + px_at(r1, c1)) / 4;
					endcase
				end
				MODE_CROP:   v = px_at(crop_row_q + r, crop_col_q + c);
				default:     v = px_at(r, c);
			endcase
			res.px = v[7:0];
			res.err = 1'b0;
		end
		return res;
	endfunction

	// track config, predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		readout_t want;
		if (!arst_n) begin
			xf_mode <= MODE_IDENT;
			frame_rows_q <= 10'd512;
			frame_cols_q <= 10'd512;
			crop_row_q <= '0;
			crop_col_q <= '0;
			crop_rows_q <= 10'd1;
			crop_cols_q <= 10'd1;
			pending_px.delete();
			reads_open <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_AW-1:2])
					REG_MODE:       xf_mode <= pwdata[3:0];
					REG_FRAME_ROWS: frame_rows_q <= pwdata[9:0];
					REG_FRAME_COLS: frame_cols_q <= pwdata[9:0];
					REG_CROP_ROW:   crop_row_q <= pwdata[8:0];
					REG_CROP_COL:   crop_col_q <= pwdata[8:0];
					REG_CROP_ROWS:  crop_rows_q <= pwdata[9:0];
					REG_CROP_COLS:  crop_cols_q <= pwdata[9:0];
					default: ;
				endcase
			end

			if (in_valid && !in_stall) begin
				if (opcode == OP_WRITE) begin
					// writes outside the frame are dropped
					if (row < frame_extent(frame_rows_q, MAX_ROWS)
							&& col < frame_extent(frame_cols_q, MAX_COLS))
						frame_px[row*MAX_COLS + col] = pixel_in;
				end else begin
					pending_px.push_back(xform_pixel(row, col));
				end
			end

			if (out_valid && !out_stall) begin
				results_checked++;
				if (pending_px.size() == 0) begin
					if (fail_total < 10)
						$display("%0t: result beat with nothing pending: pixel %0d err %0b",
							$realtime, pixel_out, range_error);
					fail_total++;
				end else begin
					want = pending_px.pop_front();
					if (pixel_out !== want.px || range_error !== want.err) begin
						if (fail_total < 10)
							$display("%0t: readout mismatch: pixel exp %0d got %0d, err exp %0b got %0b",
								$realtime, want.px, pixel_out, want.err, range_error);
						fail_total++;
					end
				end
			end

			reads_open <= pending_px.size();
		end
	end

endmodule

@@ sim/tb_frame_geometric_transform_core.sv @@
// Stimulus and verdict for the frame geometric transform core.
module tb_frame_geometric_transform_core;
	import fgt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         FRAME_MAX        = 512;
	localparam int         QUIET_LIMIT      = 4000;
	localparam int         SETTLE_CYCLES    = 16;
	localparam int         RANDOM_BEATS     = 1350;
	localparam logic [3:0] MODE_UNUSED_LAST = 4'd15;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              opcode = OP_WRITE;
	logic [9:0]        row = '0;
	logic [9:0]        col = '0;
	logic [7:0]        pixel_in = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [7:0]        pixel_out;
	logic              range_error;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int fail_total;
	int reads_open;
	int results_checked;

	// stimulus bookkeeping
	int          send_gap_pct = 14;
	int          recv_stall_pct = 63;
	int unsigned cur_rows = FRAME_MAX;
	int unsigned cur_cols = FRAME_MAX;
	logic [3:0]  cur_mode = MODE_IDENT;
	int          beats_sent = 0;
	int          reads_sent = 0;
	int          settings_done = 0;
	bit          px_written [FRAME_MAX*FRAME_MAX];

	frame_geometric_transform_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.row         (row),
		.col         (col),
		.pixel_in    (pixel_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_out   (pixel_out),
		.range_error (range_error),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	fgt_readout_checker u_readout_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.row             (row),
		.col             (col),
		.pixel_in        (pixel_in),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pixel_out       (pixel_out),
		.range_error     (range_error),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.fail_total      (fail_total),
		.reads_open      (reads_open),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver back-pressure
	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

	// quiet-cycle watchdog: any accepted beat or register access restarts it
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout after %0d quiet cycles", QUIET_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	function automatic int unsigned clip_dim(logic [9:0] v);
		int unsigned e;
		e = v;
		if (e < 1)
			e = 1;
		else if (e > FRAME_MAX)
			e = FRAME_MAX;
		return e;
	endfunction

	// one input beat, with a random gap before it
	task automatic issue_beat(logic op, logic [9:0] r, logic [9:0] c, logic [7:0] px);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		row <= r;
		col <= c;
		pixel_in <= px;
		do
			@(posedge clk);
		while (in_stall);
		if (op == OP_WRITE && r < cur_rows && c < cur_cols)
			px_written[r*FRAME_MAX + c] = 1'b1;
		beats_sent++;
		if (op == OP_READ)
			reads_sent++;
	endtask

	// hold off until every pending read has returned and the core has settled
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (reads_open != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [APB_DW-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// full register set, written only once the core is idle
	task automatic program_xform(logic [3:0] mode, logic [9:0] fr, logic [9:0] fc,
			logic [8:0] crow, logic [8:0] ccol, logic [9:0] crows, logic [9:0] ccols);
		wait_drained();
		apb_write(REG_MODE, mode);
		apb_write(REG_FRAME_ROWS, fr);
		apb_write(REG_FRAME_COLS, fc);
		apb_write(REG_CROP_ROW, crow);
		apb_write(REG_CROP_COL, ccol);
		apb_write(REG_CROP_ROWS, crows);
		apb_write(REG_CROP_COLS, ccols);
		cur_mode = mode;
		cur_rows = clip_dim(fr);
		cur_cols = clip_dim(fc);
		settings_done++;
	endtask

	initial begin
		int          random_beats;
		int          n_beats;
		int          pick;
		int unsigned span;
		logic [3:0]  mode;
		logic [9:0]  fr, fc, crows, ccols, r, c;
		logic [8:0]  crow, ccol;

		random_beats = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset config, field extremes, dropped writes
		issue_beat(OP_WRITE, 0, 0, 8'h00);
		issue_beat(OP_WRITE, 0, 1, 8'hff);
		issue_beat(OP_WRITE, 1, 0, 8'ha5);
		issue_beat(OP_WRITE, 1, 1, 8'h5a);
		issue_beat(OP_WRITE, 511, 511, 8'h3c);
		issue_beat(OP_WRITE, 511, 0, 8'hc3);
		issue_beat(OP_WRITE, 1023, 1023, 8'h77);
		issue_beat(OP_WRITE, 0, 512, 8'h11);
		issue_beat(OP_READ, 0, 0, 8'h00);
		issue_beat(OP_READ, 0, 1, 8'hff);
		issue_beat(OP_READ, 1, 1, 8'h00);
		issue_beat(OP_READ, 511, 511, 8'hff);
		issue_beat(OP_READ, 512, 0, 8'h00);
		issue_beat(OP_READ, 1023, 1023, 8'hff);
		issue_beat(OP_READ, 0, 1023, 8'h00);

		// zero frame size saturates to 1x1; upscale corner replicates the edge
		program_xform(MODE_UP2, 0, 0, 0, 0, 1, 1);
		issue_beat(OP_READ, 1, 1, 8'h00);
		issue_beat(OP_READ, 2, 0, 8'h00);
		// single-row frame gives an empty decimation
		program_xform(MODE_DOWN2, 1, 2, 0, 0, 1, 1);
		issue_beat(OP_READ, 0, 0, 8'h00);
		// oversize frame rows saturate to the maximum
		program_xform(MODE_MIRUD, 1023, 1, 0, 0, 1, 1);
		issue_beat(OP_READ, 0, 0, 8'h00);
		issue_beat(OP_READ, 512, 0, 8'h00);
		// crop: zero height counts as one, width cut at the frame edge
		program_xform(MODE_CROP, 2, 2, 0, 1, 0, 5);
		issue_beat(OP_READ, 0, 0, 8'h00);
		issue_beat(OP_READ, 0, 1, 8'h00);
		// crop origin outside the frame: empty output
		program_xform(MODE_CROP, 2, 2, 511, 0, 1, 1);
		issue_beat(OP_READ, 0, 0, 8'h00);
		// unused mode code falls back to identity
		program_xform(MODE_UNUSED_LAST, 2, 2, 0, 0, 1, 1);
		issue_beat(OP_READ, 1, 0, 8'h00);

		// random settings, each filled first so no read touches an unwritten pixel
		while (random_beats < RANDOM_BEATS) begin
			if (random_beats < RANDOM_BEATS / 3) begin
				send_gap_pct = 14;
				recv_stall_pct = 63;
			end else if (random_beats < 2 * RANDOM_BEATS / 3) begin
				send_gap_pct = 63;
				recv_stall_pct = 14;
			end else begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end

			mode = $urandom_range(0, MODE_CROP + 1);
			if (mode > MODE_CROP)
				mode = $urandom_range(MODE_CROP + 1, MODE_UNUSED_LAST);
			pick = $urandom_range(0, 11);
			case (pick)
				0: begin
					fr = $urandom_range(512, 1023);
					fc = $urandom_range(0, 1);
				end
				1: begin
					fr = $urandom_range(0, 1);
					fc = $urandom_range(512, 1023);
				end
				2: begin
					fr = 0;
					fc = $urandom_range(0, 8);
				end
				default: begin
					fr = $urandom_range(1, 12);
					fc = $urandom_range(1, 12);
				end
			endcase
			crow = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
				: $urandom_range(0, (clip_dim(fr) > 511) ? 511 : clip_dim(fr));
			ccol = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
				: $urandom_range(0, (clip_dim(fc) > 511) ? 511 : clip_dim(fc));
			crows = ($urandom_range(0, 9) == 0) ? 10'd1023 : $urandom_range(0, clip_dim(fr) + 1);
			ccols = ($urandom_range(0, 9) == 0) ? 10'd1023 : $urandom_range(0, clip_dim(fc) + 1);
			program_xform(mode, fr, fc, crow, ccol, crows, ccols);

			// fill every frame pixel not yet written
			for (int unsigned fy = 0; fy < cur_rows; fy++)
				for (int unsigned fx = 0; fx < cur_cols; fx++)
					if (!px_written[fy*FRAME_MAX + fx]) begin
						issue_beat(OP_WRITE, fy, fx, $urandom_range(0, 255));
						random_beats++;
					end

			// read coordinates mostly near the output size, a few anywhere
			span = (cur_rows > cur_cols) ? cur_rows : cur_cols;
			if (cur_mode == MODE_UP2)
				span = 2 * span;
			span = (span + 1 > 1023) ? 1023 : span + 1;
			n_beats = $urandom_range(12, 40);
			repeat (n_beats) begin
				pick = $urandom_range(0, 9);
				if (pick < 2) begin
					r = $urandom_range(0, cur_rows - 1);
					c = $urandom_range(0, cur_cols - 1);
					issue_beat(OP_WRITE, r, c, $urandom_range(0, 255));
					random_beats++;
				end else if (pick == 2) begin
					r = $urandom_range(0, 1023);
					c = $urandom_range(0, 1023);
					issue_beat(OP_WRITE, r, c, $urandom_range(0, 255));
					if (r < cur_rows && c < cur_cols)
						random_beats++;
				end else begin
					if ($urandom_range(0, 7) == 0) begin
						r = $urandom_range(0, 1023);
						c = $urandom_range(0, 1023);
					end else begin
						r = $urandom_range(0, span);
						c = $urandom_range(0, span);
					end
					issue_beat(OP_READ, r, c, $urandom_range(0, 255));
					random_beats++;
				end
			end
		end

		wait_drained();
		$display("Sent %0d input beats (%0d reads) over %0d register settings,",
			beats_sent, reads_sent, settings_done + 1);
		$display("all transform codes, 1- and 512-wide frames; %0d results compared.",
			results_checked);
		if (fail_total == 0 && reads_open == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
